@@ rtl/tdfe_pkg.sv @@
// Shared constants, codes and types of the table-driven state machine engine.
package tdfe_pkg;

  localparam int EVENT_ENTRIES_DEF  = 16;
  localparam int ACTION_ENTRIES_DEF = 16;

  localparam int OP_W   = 3;
  localparam int ST_W   = 8;
  localparam int SLOT_W = 4;
  localparam int CNT_W  = 5;
  localparam int ACT_W  = 2;
  localparam int IDX_W  = 4;
  localparam int REG_W  = 2;

  localparam logic [OP_W-1:0] OP_WR_EVENT  = 3'd0;
  localparam logic [OP_W-1:0] OP_WR_ACTION = 3'd1;
  localparam logic [OP_W-1:0] OP_POST      = 3'd2;
  localparam logic [OP_W-1:0] OP_PERFORM   = 3'd3;
  localparam logic [OP_W-1:0] OP_INIT      = 3'd4;

  localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SWITCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RUN    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FAIL   = 2'd3;

  localparam logic [REG_W-1:0] REG_EVENT_COUNT   = 2'd0;
  localparam logic [REG_W-1:0] REG_ACTION_COUNT  = 2'd1;
  localparam logic [REG_W-1:0] REG_INITIAL_STATE = 2'd2;

  localparam logic [ST_W-1:0] NO_STATE = 8'hFF;

  typedef struct packed {
    logic [ST_W-1:0] ev;
    logic [ST_W-1:0] from_st;
    logic [ST_W-1:0] to_st;
  } ev_entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage

@@ rtl/tdfe_ctrl.sv @@
// Controller of the engine: sequences accept, table scan, update and output hold.
module tdfe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output tdfe_pkg::dp_cmd_t   cmd,
  input  tdfe_pkg::dp_status_t status
);
  import tdfe_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid;
  logic       out_valid_next;
  logic       out_free;

  assign out_free  = !out_valid || m_tready;
  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = out_valid;
  assign cmd.load  = (state == S_IDLE) && s_tvalid;
  assign cmd.scan  = (state == S_SCAN);
  assign cmd.apply = (state == S_FINISH) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (status.scan_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.apply) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ rtl/tdfe_datapath.sv @@
// Datapath of the engine: registers, both tables, the scan and the result register.
module tdfe_datapath #(
  parameter int EVENT_ENTRIES  = tdfe_pkg::EVENT_ENTRIES_DEF,
  parameter int ACTION_ENTRIES = tdfe_pkg::ACTION_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tdfe_pkg::dp_cmd_t          cmd,
  output tdfe_pkg::dp_status_t       status,
  input  logic                       cfg_we,
  input  logic [tdfe_pkg::REG_W-1:0] cfg_index,
  input  logic [7:0]                 cfg_data,
  input  logic [tdfe_pkg::OP_W-1:0]  in_op,
  input  logic [tdfe_pkg::ST_W-1:0]  in_event_id,
  input  logic [tdfe_pkg::SLOT_W-1:0] in_entry_index,
  input  logic [tdfe_pkg::ST_W-1:0]  in_entry_state,
  input  logic [tdfe_pkg::ST_W-1:0]  in_entry_next,
  output logic [tdfe_pkg::ACT_W-1:0] out_action,
  output logic [tdfe_pkg::IDX_W-1:0] out_exit_index,
  output logic [tdfe_pkg::IDX_W-1:0] out_enter_index,
  output logic [tdfe_pkg::ST_W-1:0]  out_current,
  output logic [tdfe_pkg::ST_W-1:0]  out_pending
);
  import tdfe_pkg::*;

  localparam int EAW = (EVENT_ENTRIES > 1) ? $clog2(EVENT_ENTRIES) : 1;
  localparam int AAW = (ACTION_ENTRIES > 1) ? $clog2(ACTION_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] EV_CAP  =
      CNT_W'((EVENT_ENTRIES > 31) ? 31 : EVENT_ENTRIES);
  localparam logic [CNT_W-1:0] ACT_CAP =
      CNT_W'((ACTION_ENTRIES > 31) ? 31 : ACTION_ENTRIES);

  // Configuration registers.
  logic [CNT_W-1:0] event_count;
  logic [CNT_W-1:0] action_count;
  logic [ST_W-1:0]  initial_state;

  // Engine state.
  logic [ST_W-1:0] current_state;
  logic [ST_W-1:0] pending_next;
  logic            switch_flag;
  logic [ST_W-1:0] current_next;
  logic [ST_W-1:0] pending_next_next;
  logic            switch_flag_next;

  // Latched item.
  logic [OP_W-1:0]   op_q;
  logic [ST_W-1:0]   ev_q;
  logic [SLOT_W-1:0] slot_q;
  logic [ST_W-1:0]   est_q;
  logic [ST_W-1:0]   enx_q;

  // Tables.
  ev_entry_t       ev_mem  [EVENT_ENTRIES];
  logic [ST_W-1:0] act_mem [ACTION_ENTRIES];
  ev_entry_t       ev_rd;
  logic [ST_W-1:0] act_rd;

  // Scan.
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] cmp_ptr;
  logic             cmp_valid;
  logic [CNT_W-1:0] used_events;
  logic [CNT_W-1:0] used_actions;
  logic [CNT_W-1:0] lim;
  logic             issue;
  logic [CNT_W+EAW-1:0]  ev_rptr_ext;
  logic [CNT_W+AAW-1:0]  act_rptr_ext;
  logic [SLOT_W+EAW-1:0] ev_slot_ext;
  logic [SLOT_W+AAW-1:0] act_slot_ext;
  logic [EAW-1:0]   ev_raddr;
  logic [AAW-1:0]   act_raddr;
  logic [EAW-1:0]   ev_waddr;
  logic [AAW-1:0]   act_waddr;
  logic             ev_we;
  logic             act_we;

  // Scan findings.
  logic             match_found;
  logic [ST_W-1:0]  match_to;
  logic             has_cur;
  logic [IDX_W-1:0] cur_idx;
  logic             has_pend;
  logic [IDX_W-1:0] pend_idx;

  // Result of the apply step.
  logic [ACT_W-1:0] act_next;
  logic [IDX_W-1:0] xi_next;
  logic [IDX_W-1:0] ni_next;

  assign used_events  = (event_count > EV_CAP) ? EV_CAP : event_count;
  assign used_actions = (action_count > ACT_CAP) ? ACT_CAP : action_count;

  always_comb begin
    case (op_q)
      OP_POST:    lim = used_events;
      OP_PERFORM: lim = used_actions;
      default:    lim = '0;
    endcase
  end

  assign issue            = cmd.scan && (ptr < lim);
  assign status.scan_done = (ptr >= lim) && !cmp_valid;

  assign ev_rptr_ext  = {{EAW{1'b0}}, ptr};
  assign act_rptr_ext = {{AAW{1'b0}}, ptr};
  assign ev_slot_ext  = {{EAW{1'b0}}, slot_q};
  assign act_slot_ext = {{AAW{1'b0}}, slot_q};
  assign ev_raddr     = ev_rptr_ext[EAW-1:0];
  assign act_raddr    = act_rptr_ext[AAW-1:0];
  assign ev_waddr     = ev_slot_ext[EAW-1:0];
  assign act_waddr    = act_slot_ext[AAW-1:0];
  assign ev_we  = cmd.apply && (op_q == OP_WR_EVENT) && (int'(slot_q) < EVENT_ENTRIES);
  assign act_we = cmd.apply && (op_q == OP_WR_ACTION) && (int'(slot_q) < ACTION_ENTRIES);

  always_ff @(posedge clk) begin
    if (ev_we) begin
      ev_mem[ev_waddr] <= '{ev: ev_q, from_st: est_q, to_st: enx_q};
    end
    ev_rd <= ev_mem[ev_raddr];
  end

  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[act_waddr] <= est_q;
    end
    act_rd <= act_mem[act_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_count   <= '0;
      action_count  <= '0;
      initial_state <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EVENT_COUNT:   event_count   <= cfg_data[CNT_W-1:0];
        REG_ACTION_COUNT:  action_count  <= cfg_data[CNT_W-1:0];
        REG_INITIAL_STATE: initial_state <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= in_op;
      ev_q   <= in_event_id;
      slot_q <= in_entry_index;
      est_q  <= in_entry_state;
      enx_q  <= in_entry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      cmp_valid <= 1'b0;
    end else if (cmd.load) begin
      ptr       <= '0;
      cmp_valid <= 1'b0;
    end else begin
      if (issue) ptr <= ptr + 1'b1;
      cmp_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    cmp_ptr <= ptr;
    if (cmd.load) begin
      match_found <= 1'b0;
      has_cur     <= 1'b0;
      has_pend    <= 1'b0;
    end else if (cmp_valid) begin
      if (op_q == OP_POST && !match_found && ev_rd.ev == ev_q
          && ev_rd.from_st == current_state) begin
        match_found <= 1'b1;
        match_to    <= ev_rd.to_st;
      end
      if (op_q == OP_PERFORM) begin
        if (!has_cur && act_rd == current_state) begin
          has_cur <= 1'b1;
          cur_idx <= cmp_ptr[IDX_W-1:0];
        end
        if (!has_pend && act_rd == pending_next) begin
          has_pend <= 1'b1;
          pend_idx <= cmp_ptr[IDX_W-1:0];
        end
      end
    end
  end

  always_comb begin
    current_next      = current_state;
    pending_next_next = pending_next;
    switch_flag_next  = switch_flag;
    act_next          = ACT_NONE;
    xi_next           = '0;
    ni_next           = '0;
    case (op_q)
      OP_POST: begin
        if (match_found) begin
          pending_next_next = match_to;
          switch_flag_next  = 1'b1;
        end
      end
      OP_PERFORM: begin
        if (switch_flag) begin
          switch_flag_next = 1'b0;
          if (has_cur && has_pend) begin
            act_next          = ACT_SWITCH;
            xi_next           = cur_idx;
            ni_next           = pend_idx;
            current_next      = pending_next;
            pending_next_next = NO_STATE;
          end else begin
            act_next = ACT_FAIL;
          end
        end else if (has_cur) begin
          act_next = ACT_RUN;
          xi_next  = cur_idx;
        end
      end
      OP_INIT: begin
        current_next      = initial_state;
        pending_next_next = '0;
        switch_flag_next  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_state <= '0;
      pending_next  <= '0;
      switch_flag   <= 1'b0;
    end else if (cmd.apply) begin
      current_state <= current_next;
      pending_next  <= pending_next_next;
      switch_flag   <= switch_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_action      <= act_next;
      out_exit_index  <= xi_next;
      out_enter_index <= ni_next;
      out_current     <= current_next;
      out_pending     <= pending_next_next;
    end
  end

endmodule

@@ rtl/table_driven_fsm_engine_unit.sv @@
// Top level of the table-driven state machine engine.
// Table writes, init, unknown ops and scans over zero entries read no table entry; a post
// scans n = min(event_count, EVENT_ENTRIES) entries and a perform scans
// n = min(action_count, ACTION_ENTRIES) entries before the result is applied.
// One transaction at a time: an item is taken only in idle, also while a result waits.
// Reset clears control, counts and engine state; the tables hold no reset value.
module table_driven_fsm_engine_unit #(
  parameter int EVENT_ENTRIES  = tdfe_pkg::EVENT_ENTRIES_DEF,
  parameter int ACTION_ENTRIES = tdfe_pkg::ACTION_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // event_id[7:0], entry_index[11:8], entry_state[19:12], entry_next[27:20]
  input  logic [31:0] s_tdata,
  // op[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // exit_index[3:0], enter_index[7:4], current_out[15:8], pending_out[23:16]
  output logic [23:0] m_tdata,
  // action[1:0]
  output logic [1:0]  m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import tdfe_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  tdfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  tdfe_datapath #(
    .EVENT_ENTRIES  (EVENT_ENTRIES),
    .ACTION_ENTRIES (ACTION_ENTRIES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_op           (s_tuser),
    .in_event_id     (s_tdata[7:0]),
    .in_entry_index  (s_tdata[11:8]),
    .in_entry_state  (s_tdata[19:12]),
    .in_entry_next   (s_tdata[27:20]),
    .out_action      (m_tuser),
    .out_exit_index  (m_tdata[3:0]),
    .out_enter_index (m_tdata[7:4]),
    .out_current     (m_tdata[15:8]),
    .out_pending     (m_tdata[23:16])
  );

endmodule

@@ rtl/tdfe_checker.sv @@
// Port-level checks of the engine and their binding to the top level.
module tdfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import tdfe_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("engine not idle after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_idle_indices: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ACT_NONE || m_tuser == ACT_FAIL) |-> m_tdata[7:0] == 8'h00)
    else $error("indices reported without an action");

  a_switch_pending: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ACT_SWITCH |-> m_tdata[23:16] == NO_STATE)
    else $error("pending state not cleared by a transition");

endmodule

bind table_driven_fsm_engine_unit tdfe_checker u_tdfe_checker (.*);
